// File: rtl/core/sorted_wakeup_timer_queue_assert.svh
// Assertion shorthands used by the checker file swtq_chk.sv.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define SWTQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swtq: same-cycle check failed");

// Check the consequent in the cycle after the antecedent.
`define SWTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swtq: next-cycle check failed");

`endif

// File: rtl/core/swtq_pkg.sv
package swtq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int MAX_RESULTS    = 16;
    localparam int ID_W           = 4;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] RESP_INSERT = 2'd0;
    localparam logic [1:0] RESP_REMOVE = 2'd1;
    localparam logic [1:0] RESP_WOKEN  = 2'd2;
    localparam logic [1:0] RESP_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] task_id;
        logic [31:0]     wakeup_time;
        logic [31:0]     now_time;
    } t_req;

    typedef struct packed {
        logic [1:0]      resp_kind;
        logic [ID_W-1:0] woken_id;
        logic            found;
        logic            status;
        logic            last;
    } t_resp;

endpackage

// File: rtl/core/sorted_wakeup_timer_queue.sv
// Every word is registered and leaves in the cycle after it is decided; an insert into an
// empty or full queue, and a remove or tick on an empty queue, answer in the cycle after start.
// Busy after accept: an insert searches, shifts from tail to slot and writes; a remove
// searches and, on a hit, shifts the later entries up; a tick finds the due entries, then
// closes the gap, or answers RESP_NONE when none is due; a new word is taken only while idle.
// Synchronous active-low reset empties the queue; results cannot be stalled by the receiver.
module sorted_wakeup_timer_queue #(
    parameter int DEPTH      = swtq_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = swtq_pkg::TIME_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  swtq_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_valid,
    output swtq_pkg::t_resp o_resp
);

    localparam int IW = $clog2(DEPTH);
    localparam int EW = swtq_pkg::ID_W + TIME_WIDTH;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    swtq_seq #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_resp      (o_resp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    swtq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// File: rtl/core/swtq_mem.sv
module swtq_mem #(
    parameter int DEPTH = swtq_pkg::DEPTH_DEF,
    parameter int WIDTH = swtq_pkg::ID_W + swtq_pkg::TIME_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/swtq_seq.sv
module swtq_seq #(
    parameter int DEPTH      = swtq_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = swtq_pkg::TIME_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  swtq_pkg::t_req                          i_req,
    output logic                                    o_busy,
    output logic                                    o_valid,
    output swtq_pkg::t_resp                         o_resp,
    output logic                                    o_mem_we,
    output logic [$clog2(DEPTH)-1:0]                o_mem_waddr,
    output logic [swtq_pkg::ID_W+TIME_WIDTH-1:0]    o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]                o_mem_raddr,
    input  logic [swtq_pkg::ID_W+TIME_WIDTH-1:0]    i_mem_rdata
);

    localparam int IW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int TW      = TIME_WIDTH;
    localparam int EW      = swtq_pkg::ID_W + TW;
    localparam int REL_LIM = (swtq_pkg::MAX_RESULTS < DEPTH) ? swtq_pkg::MAX_RESULTS : DEPTH;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_INS_FIND  = 9'b000000010,
        S_INS_SHIFT = 9'b000000100,
        S_INS_PUT   = 9'b000001000,
        S_REM_FIND  = 9'b000010000,
        S_REM_SHIFT = 9'b000100000,
        S_TICK      = 9'b001000000,
        S_TICK_LAST = 9'b010000000,
        S_PACK      = 9'b100000000
    } t_state;

    t_state                    r_state, n_state;
    logic [IW-1:0]             r_ptr, n_ptr;
    logic [IW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_rel, n_rel;
    logic [CW-1:0]             r_count, n_count;
    logic [swtq_pkg::ID_W-1:0] r_id, n_id;
    logic [swtq_pkg::ID_W-1:0] r_pend, n_pend;
    logic [TW-1:0]             r_wake, n_wake;
    logic [TW-1:0]             r_now, n_now;
    logic                      r_valid, n_valid;
    swtq_pkg::t_resp           r_resp, n_resp;

    logic [swtq_pkg::ID_W-1:0] rd_id;
    logic [TW-1:0]             rd_time;
    logic [TW-1:0]             cmp_a, cmp_b, cmp_diff;
    logic                      cmp_later;
    logic [CW-1:0]             ptr_inc;
    logic                      at_tail;
    logic                      rel_cap;

    assign rd_id   = i_mem_rdata[EW-1 -: swtq_pkg::ID_W];
    assign rd_time = i_mem_rdata[TW-1:0];

    always_comb begin
        cmp_a = r_wake;
        cmp_b = rd_time;
        if (r_state == S_TICK) begin
            cmp_a = r_now;
        end else if (r_state == S_INS_FIND && r_ptr == '0) begin
            cmp_a = rd_time;
            cmp_b = r_wake;
        end
    end

    assign cmp_diff  = cmp_b - cmp_a;
    assign cmp_later = cmp_diff[TW-1];

    assign ptr_inc = CW'(r_ptr) + CW'(1);
    assign at_tail = (ptr_inc == r_count);
    assign rel_cap = (ptr_inc == CW'(REL_LIM));

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_rel       = r_rel;
        n_count     = r_count;
        n_id        = r_id;
        n_pend      = r_pend;
        n_wake      = r_wake;
        n_now       = r_now;
        n_valid     = 1'b0;
        n_resp      = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr;
        o_mem_wdata = i_mem_rdata;

        unique case (r_state)
            S_IDLE: begin
                n_ptr = '0;
                if (i_start) begin
                    n_id   = i_req.task_id;
                    n_wake = TW'(i_req.wakeup_time);
                    n_now  = TW'(i_req.now_time);
                    unique case (i_req.req_type)
                        swtq_pkg::REQ_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_valid          = 1'b1;
                                n_resp.resp_kind = swtq_pkg::RESP_INSERT;
                                n_resp.status    = 1'b1;
                                n_resp.last      = 1'b1;
                            end else if (r_count == '0) begin
                                o_mem_we         = 1'b1;
                                o_mem_waddr      = '0;
                                o_mem_wdata      = {i_req.task_id, TW'(i_req.wakeup_time)};
                                n_count          = r_count + CW'(1);
                                n_valid          = 1'b1;
                                n_resp.resp_kind = swtq_pkg::RESP_INSERT;
                                n_resp.last      = 1'b1;
                            end else begin
                                n_state = S_INS_FIND;
                            end
                        end
                        swtq_pkg::REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_valid          = 1'b1;
                                n_resp.resp_kind = swtq_pkg::RESP_REMOVE;
                                n_resp.last      = 1'b1;
                            end else begin
                                n_state = S_REM_FIND;
                            end
                        end
                        swtq_pkg::REQ_TICK: begin
                            if (r_count == '0) begin
                                n_valid          = 1'b1;
                                n_resp.resp_kind = swtq_pkg::RESP_NONE;
                                n_resp.last      = 1'b1;
                            end else begin
                                n_state = S_TICK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_INS_FIND: begin
                if ((r_ptr == '0) ? cmp_later : !cmp_later) begin
                    n_pos   = r_ptr;
                    n_ptr   = IW'(r_count - CW'(1));
                    n_state = S_INS_SHIFT;
                end else if (at_tail) begin
                    n_pos   = IW'(r_count);
                    n_state = S_INS_PUT;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end

            S_INS_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr + IW'(1);
                if (r_ptr == r_pos) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_ptr = r_ptr - IW'(1);
                end
            end

            S_INS_PUT: begin
                o_mem_we         = 1'b1;
                o_mem_waddr      = r_pos;
                o_mem_wdata      = {r_id, r_wake};
                n_count          = r_count + CW'(1);
                n_valid          = 1'b1;
                n_resp.resp_kind = swtq_pkg::RESP_INSERT;
                n_resp.last      = 1'b1;
                n_state          = S_IDLE;
            end

            S_REM_FIND: begin
                if (rd_id == r_id) begin
                    if (at_tail) begin
                        n_count          = r_count - CW'(1);
                        n_valid          = 1'b1;
                        n_resp.resp_kind = swtq_pkg::RESP_REMOVE;
                        n_resp.found     = 1'b1;
                        n_resp.last      = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + IW'(1);
                        n_state = S_REM_SHIFT;
                    end
                end else if (at_tail) begin
                    n_valid          = 1'b1;
                    n_resp.resp_kind = swtq_pkg::RESP_REMOVE;
                    n_resp.last      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end

            S_REM_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr - IW'(1);
                if (at_tail) begin
                    n_count          = r_count - CW'(1);
                    n_valid          = 1'b1;
                    n_resp.resp_kind = swtq_pkg::RESP_REMOVE;
                    n_resp.found     = 1'b1;
                    n_resp.last      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end

            S_TICK: begin
                if (cmp_later) begin
                    if (r_ptr != '0) begin
                        n_valid          = 1'b1;
                        n_resp.resp_kind = swtq_pkg::RESP_WOKEN;
                        n_resp.woken_id  = r_pend;
                    end
                    n_pend = rd_id;
                    if (at_tail || rel_cap) begin
                        n_rel   = ptr_inc;
                        n_state = S_TICK_LAST;
                    end else begin
                        n_ptr = r_ptr + IW'(1);
                    end
                end else if (r_ptr == '0) begin
                    n_valid          = 1'b1;
                    n_resp.resp_kind = swtq_pkg::RESP_NONE;
                    n_resp.last      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_valid          = 1'b1;
                    n_resp.resp_kind = swtq_pkg::RESP_WOKEN;
                    n_resp.woken_id  = r_pend;
                    n_resp.last      = 1'b1;
                    n_rel            = CW'(r_ptr);
                    n_state          = S_PACK;
                end
            end

            S_TICK_LAST: begin
                n_valid          = 1'b1;
                n_resp.resp_kind = swtq_pkg::RESP_WOKEN;
                n_resp.woken_id  = r_pend;
                n_resp.last      = 1'b1;
                if (r_rel == r_count) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = IW'(r_rel);
                    n_state = S_PACK;
                end
            end

            S_PACK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = IW'(CW'(r_ptr) - r_rel);
                if (at_tail) begin
                    n_count = r_count - r_rel;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_pos  <= n_pos;
        r_rel  <= n_rel;
        r_id   <= n_id;
        r_pend <= n_pend;
        r_wake <= n_wake;
        r_now  <= n_now;
        r_resp <= n_resp;
    end

    assign o_mem_raddr = n_ptr;
    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_resp      = r_resp;

endmodule

// File: rtl/core/swtq_chk.sv
`include "sorted_wakeup_timer_queue_assert.svh"

module swtq_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input swtq_pkg::t_req  i_req,
    input logic            busy,
    input logic            o_valid,
    input swtq_pkg::t_resp o_resp
);

    logic req_known;

    assign req_known = (i_req.req_type == swtq_pkg::REQ_INSERT) ||
                       (i_req.req_type == swtq_pkg::REQ_REMOVE) ||
                       (i_req.req_type == swtq_pkg::REQ_TICK);

    `SWTQ_ASSERT_NEXT(a_idle_quiet, !busy && !start, !o_valid)
    `SWTQ_ASSERT_NEXT(a_accept_acts, start && !busy && req_known, o_valid || busy)
    `SWTQ_ASSERT_SAME(a_more_pending, o_valid && !o_resp.last, busy)
    `SWTQ_ASSERT_SAME(a_none_due_form, o_valid && o_resp.resp_kind == swtq_pkg::RESP_NONE, o_resp.last && o_resp.woken_id == 4'd0)

endmodule

bind sorted_wakeup_timer_queue swtq_chk u_swtq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_resp  (o_resp)
);

// File: dv/tb_sorted_wakeup_timer_queue.sv
`timescale 1ns / 1ps

module tb_sorted_wakeup_timer_queue;
    import swtq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 8;
    localparam int PHASE_ITEMS = 70;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam t_resp W_ACK  = '{RESP_INSERT, 4'd0, 1'b0, 1'b0, 1'b1};
    localparam t_resp W_FULL = '{RESP_INSERT, 4'd0, 1'b0, 1'b1, 1'b1};
    localparam t_resp W_HIT  = '{RESP_REMOVE, 4'd0, 1'b1, 1'b0, 1'b1};
    localparam t_resp W_MISS = '{RESP_REMOVE, 4'd0, 1'b0, 1'b0, 1'b1};
    localparam t_resp W_NONE = '{RESP_NONE, 4'd0, 1'b0, 1'b0, 1'b1};

    typedef struct {
        t_req  req;
        bit    typed;
        t_resp want;
    } t_stim_row;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_valid;
    t_resp o_resp;

    logic [3:0]  sleeper_ids  [DEPTH];
    logic [31:0] sleeper_wake [DEPTH];
    int          sleeper_count = 0;

    t_resp fresh_words[$];
    t_resp awaited_words[$];
    t_resp head_word;

    int fails         = 0;
    int cycle_count   = 0;
    int idle_pct      = 0;
    int words_checked = 0;
    int inserts_sent  = 0;
    int removes_sent  = 0;
    int ticks_sent    = 0;
    int full_drops    = 0;
    int released      = 0;
    int peak_fill     = 0;

    sorted_wakeup_timer_queue #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_resp  (o_resp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit wakes_after(logic [31:0] a, logic [31:0] b);
        logic [31:0] gap;
        gap = b - a;
        return gap[31];
    endfunction

    function automatic void drop_sleeper(int pos);
        int i;
        for (i = pos; i + 1 < sleeper_count; i++) begin
            sleeper_ids[i]  = sleeper_ids[i + 1];
            sleeper_wake[i] = sleeper_wake[i + 1];
        end
        sleeper_count--;
    endfunction

    function automatic void advance_sleepers(t_req r);
        int    pos;
        int    i;
        int    n;
        t_resp w;
        fresh_words.delete();
        w = '0;
        case (r.req_type)
            REQ_INSERT: begin
                w.resp_kind = RESP_INSERT;
                w.last      = 1'b1;
                if (sleeper_count >= DEPTH) begin
                    w.status = 1'b1;
                    full_drops++;
                end else begin
                    if (sleeper_count == 0 || wakes_after(sleeper_wake[0], r.wakeup_time)) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < sleeper_count &&
                               wakes_after(r.wakeup_time, sleeper_wake[pos]))
                            pos++;
                    end
                    for (i = sleeper_count; i > pos; i--) begin
                        sleeper_ids[i]  = sleeper_ids[i - 1];
                        sleeper_wake[i] = sleeper_wake[i - 1];
                    end
                    sleeper_ids[pos]  = r.task_id;
                    sleeper_wake[pos] = r.wakeup_time;
                    sleeper_count++;
                    if (sleeper_count > peak_fill) peak_fill = sleeper_count;
                end
                fresh_words.push_back(w);
            end
            REQ_REMOVE: begin
                w.resp_kind = RESP_REMOVE;
                w.last      = 1'b1;
                for (pos = 0; pos < sleeper_count; pos++) begin
                    if (sleeper_ids[pos] == r.task_id) break;
                end
                if (pos < sleeper_count) begin
                    drop_sleeper(pos);
                    w.found = 1'b1;
                end
                fresh_words.push_back(w);
            end
            REQ_TICK: begin
                n = 0;
                while (n < MAX_RESULTS && sleeper_count > 0 &&
                       wakes_after(r.now_time, sleeper_wake[0])) begin
                    w.resp_kind = RESP_WOKEN;
                    w.woken_id  = sleeper_ids[0];
                    fresh_words.push_back(w);
                    drop_sleeper(0);
                    n++;
                end
                released += n;
                if (n == 0) fresh_words.push_back(W_NONE);
                else fresh_words[n - 1].last = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_words.size() == 0) begin
                $error("unexpected word: kind %0d id %0d", o_resp.resp_kind, o_resp.woken_id);
                fails++;
            end else begin
                head_word = awaited_words.pop_front();
                check_field("resp_kind", head_word.resp_kind, o_resp.resp_kind);
                check_field("woken_id", head_word.woken_id, o_resp.woken_id);
                check_field("found", head_word.found, o_resp.found);
                check_field("status", head_word.status, o_resp.status);
                check_field("last", head_word.last, o_resp.last);
                words_checked++;
            end
        end
    end

    task automatic issue(t_req r, bit typed, t_resp want);
        int k;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (r.req_type)
            REQ_INSERT: inserts_sent++;
            REQ_REMOVE: removes_sent++;
            REQ_TICK:   ticks_sent++;
            default:    ;
        endcase
        advance_sleepers(r);
        if (typed) awaited_words.push_back(want);
        else for (k = 0; k < fresh_words.size(); k++) awaited_words.push_back(fresh_words[k]);
    endtask

    function automatic t_stim_row mk(logic [1:0] kind, logic [3:0] id, logic [31:0] wake,
                                     logic [31:0] now, bit typed, t_resp want);
        t_stim_row row;
        row.req.req_type    = kind;
        row.req.task_id     = id;
        row.req.wakeup_time = wake;
        row.req.now_time    = now;
        row.typed           = typed;
        row.want            = want;
        return row;
    endfunction

    function automatic t_req random_word(logic [1:0] kind);
        t_req r;
        r.req_type    = kind;
        r.task_id     = 4'($urandom);
        r.wakeup_time = $urandom;
        r.now_time    = $urandom;
        return r;
    endfunction

    initial begin
        t_stim_row   script [25];
        t_req        r;
        logic [31:0] clock_now;
        int          phase;
        int          n;
        int          pick;
        int          row;

        script[0]  = mk(REQ_TICK,   4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, W_NONE);
        script[1]  = mk(REQ_REMOVE, 4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, W_MISS);
        script[2]  = mk(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0);
        script[3]  = mk(REQ_INSERT, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, W_ACK);
        script[4]  = mk(REQ_INSERT, 4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, W_ACK);
        script[5]  = mk(REQ_INSERT, 4'd3,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, W_ACK);
        script[6]  = mk(REQ_INSERT, 4'd15, 32'h0000_0000, 32'h0000_0000, 1'b1, W_ACK);
        script[7]  = mk(REQ_INSERT, 4'd5,  32'h0000_0000, 32'h0000_0000, 1'b1, W_ACK);
        script[8]  = mk(REQ_INSERT, 4'd10, 32'h8000_0000, 32'h0000_0000, 1'b1, W_ACK);
        script[9]  = mk(REQ_INSERT, 4'd1,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, W_ACK);
        script[10] = mk(REQ_INSERT, 4'd2,  32'h0000_0001, 32'h0000_0000, 1'b1, W_ACK);
        script[11] = mk(REQ_INSERT, 4'd4,  32'h0000_1000, 32'h0000_0000, 1'b1, W_ACK);
        script[12] = mk(REQ_INSERT, 4'd6,  32'h0000_1000, 32'h0000_0000, 1'b1, W_ACK);
        script[13] = mk(REQ_INSERT, 4'd7,  32'h0000_0800, 32'h0000_0000, 1'b1, W_ACK);
        script[14] = mk(REQ_INSERT, 4'd8,  32'h1234_5678, 32'h0000_0000, 1'b1, W_ACK);
        script[15] = mk(REQ_INSERT, 4'd9,  32'h0000_0010, 32'h0000_0000, 1'b1, W_ACK);
        script[16] = mk(REQ_INSERT, 4'd12, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1, W_ACK);
        script[17] = mk(REQ_INSERT, 4'd13, 32'h0000_2000, 32'h0000_0000, 1'b1, W_ACK);
        script[18] = mk(REQ_INSERT, 4'd14, 32'h0000_0001, 32'h0000_0000, 1'b1, W_ACK);
        script[19] = mk(REQ_INSERT, 4'd11, 32'h0000_0000, 32'h0000_0000, 1'b1, W_FULL);
        script[20] = mk(REQ_REMOVE, 4'd15, 32'h0000_0000, 32'h0000_0000, 1'b1, W_HIT);
        script[21] = mk(REQ_REMOVE, 4'd11, 32'h0000_0000, 32'h0000_0000, 1'b1, W_MISS);
        script[22] = mk(REQ_TICK,   4'd0,  32'h0000_0000, 32'h0000_1000, 1'b0, '0);
        script[23] = mk(REQ_TICK,   4'd0,  32'h0000_0000, 32'h0000_1000, 1'b0, '0);
        script[24] = mk(REQ_TICK,   4'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 8;
        for (row = 0; row < 25; row++) issue(script[row].req, script[row].typed, script[row].want);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       idle_pct = 8;
                1:       idle_pct = 52;
                default: idle_pct = 0;
            endcase
            clock_now = (phase == 2) ? 32'hFFFF_FF00 : $urandom;
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (n == 20) begin
                    // fill to overflow, then release the whole burst
                    repeat (DEPTH + 1 - sleeper_count) begin
                        r = random_word(REQ_INSERT);
                        r.wakeup_time = clock_now + $urandom_range(1, 50);
                        issue(r, 1'b0, '0);
                        n++;
                    end
                    clock_now += 100;
                    r = random_word(REQ_TICK);
                    r.now_time = clock_now;
                    issue(r, 1'b0, '0);
                    n++;
                end
                pick = $urandom_range(99);
                if (pick < 3) begin
                    issue(random_word(REQ_UNUSED), 1'b0, '0);
                end else if (pick < 45) begin
                    r = random_word(REQ_INSERT);
                    if (sleeper_count > 0 && $urandom_range(9) == 0)
                        r.wakeup_time = sleeper_wake[$urandom_range(sleeper_count - 1)];
                    else if ($urandom_range(9) != 0)
                        r.wakeup_time = clock_now + $urandom_range(0, 300);
                    issue(r, 1'b0, '0);
                    n++;
                end else if (pick < 65) begin
                    r = random_word(REQ_REMOVE);
                    if (sleeper_count > 0 && $urandom_range(4) != 0)
                        r.task_id = sleeper_ids[$urandom_range(sleeper_count - 1)];
                    issue(r, 1'b0, '0);
                    n++;
                end else begin
                    r = random_word(REQ_TICK);
                    clock_now += $urandom_range(0, 120);
                    if (sleeper_count > 0 && $urandom_range(9) == 0)
                        r.now_time = sleeper_wake[0];
                    else if ($urandom_range(19) != 0)
                        r.now_time = clock_now;
                    issue(r, 1'b0, '0);
                    n++;
                end
            end
        end

        start <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d inserts (%0d dropped on full, peak fill %0d), %0d removes,",
                 inserts_sent, full_drops, peak_fill, removes_sent);
        $display("%0d ticks releasing %0d sleepers; %0d words checked, %0d mismatches",
                 ticks_sent, released, words_checked, fails);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/swtq_pkg.sv
rtl/core/swtq_mem.sv
rtl/core/swtq_seq.sv
rtl/core/sorted_wakeup_timer_queue.sv
rtl/core/swtq_chk.sv
dv/tb_sorted_wakeup_timer_queue.sv
